@@ hw/rtl/tally_link_keepalive_supervisor_macros.svh @@
// ----------------------------------------------------------------------------
// Tally link supervisor assertion macros
// Shorthand for the clocked checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TALLY_LINK_KEEPALIVE_SUPERVISOR_MACROS_SVH
`define TALLY_LINK_KEEPALIVE_SUPERVISOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define TLKS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tlks: same-cycle check failed");

// next-cycle implication, disabled in reset
`define TLKS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tlks: next-cycle check failed");

// checked across reset
`define TLKS_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error("tlks: reset check failed");

`endif

@@ hw/rtl/tlks_pkg.sv @@
// ----------------------------------------------------------------------------
// tlks_pkg
// Types, codes and constants shared by the tally link supervisor modules.
// ----------------------------------------------------------------------------
package tlks_pkg;

    localparam int unsigned RETRY_INTERVAL_MS = 1000;
    localparam int unsigned MS_W              = 22;   // 4095 s * 1000 fits
    localparam logic [7:0]  BYTE_ALL_ONES     = 8'hFF;
    localparam logic [31:0] TIME_NONE         = 32'hFFFF_FFFF;
    localparam logic [15:0] SECS_NONE         = 16'hFFFF;
    localparam logic [21:0] ROUND_UP_MS       = 22'd999;
    // x / 1000 == ((x >> 3) * RECIP_125) >> RECIP_SHIFT for x < 2^22
    localparam logic [19:0] RECIP_125         = 20'd536871;
    localparam int unsigned RECIP_SHIFT       = 26;

    typedef enum logic [1:0] {
        OP_DISCONNECTED = 2'd0,
        OP_RX_PAIR      = 2'd1,
        OP_CONNECTED    = 2'd2,
        OP_RESERVED     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_LISTEN_INPUT    = 2'd0,
        REG_KEEPALIVE_SEC   = 2'd1,
        REG_RESTART_SEC     = 2'd2,
        REG_SHOW_PREVIEW    = 2'd3
    } reg_idx_t;

    typedef enum logic [7:0] {
        TALLY_OFF      = 8'd0,
        TALLY_PREVIEW  = 8'd1,
        TALLY_PROGRAM  = 8'd2,
        TALLY_BOTH     = 8'd3
    } tally_code_t;

    typedef struct packed {
        logic [7:0]      listen_input;
        logic [MS_W-1:0] keepalive_ms;
        logic [MS_W-1:0] restart_ms;
        logic            show_preview;
        logic            clear_link;    // pulse: drop attempt run and throttle
    } cfg_t;

    typedef struct packed {
        logic [7:0]  msg_second;
        logic [7:0]  msg_first;
        logic        connect_ok;
        logic [31:0] now_ms;
        logic [1:0]  operation;
    } item_t;

    typedef struct packed {
        logic [15:0] warning_seconds;
        logic        warning_valid;
        logic        program_lamp;
        logic        preview_lamp;
        logic        message_ignored;
        logic        restart_request;
        logic        send_keepalive;
        logic        send_hello;
    } result_t;

    // seconds to milliseconds by shifts: v*1000 = v*1024 - v*16 - v*8
    function automatic logic [MS_W-1:0] sec_to_ms(input logic [11:0] sec);
        logic [MS_W-1:0] v;
        v = {{(MS_W-12){1'b0}}, sec};
        return (v << 10) - (v << 4) - (v << 3);
    endfunction

endpackage

@@ hw/rtl/tlks_regs.sv @@
// ----------------------------------------------------------------------------
// tlks_regs
// APB register file; keeps the timeouts also in milliseconds.
// ----------------------------------------------------------------------------
module tlks_regs
    import tlks_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [7:0]      listen_reg;
    logic [11:0]     ka_sec_reg;
    logic [11:0]     rs_sec_reg;
    logic            show_prev_reg;
    logic [MS_W-1:0] ka_ms_reg;
    logic [MS_W-1:0] rs_ms_reg;
    logic            wr_en;
    reg_idx_t        idx;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            listen_reg    <= 8'd0;
            ka_sec_reg    <= 12'd5;
            rs_sec_reg    <= 12'd30;
            show_prev_reg <= 1'b1;
            ka_ms_reg     <= sec_to_ms(12'd5);
            rs_ms_reg     <= sec_to_ms(12'd30);
        end else if (wr_en) begin
            unique case (idx)
                REG_LISTEN_INPUT: listen_reg <= pwdata[7:0];
                REG_KEEPALIVE_SEC: begin
                    ka_sec_reg <= pwdata[11:0];
                    ka_ms_reg  <= sec_to_ms(pwdata[11:0]);
                end
                REG_RESTART_SEC: begin
                    rs_sec_reg <= pwdata[11:0];
                    rs_ms_reg  <= sec_to_ms(pwdata[11:0]);
                end
                REG_SHOW_PREVIEW: show_prev_reg <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_LISTEN_INPUT:  prdata = {24'd0, listen_reg};
            REG_KEEPALIVE_SEC: prdata = {20'd0, ka_sec_reg};
            REG_RESTART_SEC:   prdata = {20'd0, rs_sec_reg};
            REG_SHOW_PREVIEW:  prdata = {31'd0, show_prev_reg};
        endcase
    end

    assign cfg.listen_input = listen_reg;
    assign cfg.keepalive_ms = ka_ms_reg;
    assign cfg.restart_ms   = rs_ms_reg;
    assign cfg.show_preview = show_prev_reg;
    // timing registers and listen input restart the connect attempt run
    assign cfg.clear_link   = wr_en && (idx != REG_SHOW_PREVIEW);

endmodule

@@ hw/rtl/tlks_core.sv @@
// ----------------------------------------------------------------------------
// tlks_core
// Link state registers and the combinational update for a single transaction.
// ----------------------------------------------------------------------------
module tlks_core
    import tlks_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    step_en,
    input  item_t   item,
    output result_t res
);

    logic [31:0] att_start_reg, att_start_next;
    logic        att_vld_reg, att_vld_next;
    logic [31:0] last_att_reg, last_att_next;
    logic        last_vld_reg, last_vld_next;
    logic [31:0] ka_sent_reg, ka_sent_next;
    logic [31:0] reply_reg, reply_next;
    logic [15:0] warned_reg, warned_next;
    logic        prev_reg, prev_next;
    logic        prog_reg, prog_next;

    logic [31:0] now;
    logic [31:0] start_eff;
    logic        throttled;
    logic        fail_expired;
    logic        reply_late;
    logic [31:0] elapsed;
    logic        reply_expired;
    logic        ka_due;
    logic [MS_W-1:0] remain_ms;
    logic [MS_W-1:0] round_ms;
    logic [38:0] quot_prod;
    logic [15:0] secs;
    logic        restart;

    assign now       = item.now_ms;
    assign start_eff = att_vld_reg ? att_start_reg : now;
    assign throttled = last_vld_reg && ((now - last_att_reg) < 32'(RETRY_INTERVAL_MS));
    assign fail_expired = (now - start_eff) >= {{(32-MS_W){1'b0}}, cfg.restart_ms};

    // a reply at least one keep-alive period behind the last frame sent
    assign reply_late = (reply_reg < ka_sent_reg) &&
                        ((ka_sent_reg - reply_reg) >= {{(32-MS_W){1'b0}}, cfg.keepalive_ms});
    assign elapsed       = now - reply_reg;
    assign reply_expired = elapsed >= {{(32-MS_W){1'b0}}, cfg.restart_ms};
    assign ka_due        = (now - ka_sent_reg) >= {{(32-MS_W){1'b0}}, cfg.keepalive_ms};

    // ceil(remaining / 1000); elapsed < restart_ms here so it fits MS_W bits
    assign remain_ms = cfg.restart_ms - elapsed[MS_W-1:0];
    assign round_ms  = remain_ms + ROUND_UP_MS;
    assign quot_prod = 39'(round_ms[MS_W-1:3]) * 39'(RECIP_125);
    assign secs      = {3'd0, quot_prod[38:RECIP_SHIFT]};

    always_comb begin
        att_start_next = att_start_reg;
        att_vld_next   = att_vld_reg;
        last_att_next  = last_att_reg;
        last_vld_next  = last_vld_reg;
        ka_sent_next   = ka_sent_reg;
        reply_next     = reply_reg;
        warned_next    = warned_reg;
        prev_next      = prev_reg;
        prog_next      = prog_reg;
        restart        = 1'b0;
        res            = '0;

        if (step_en) begin
            unique case (op_t'(item.operation))
                OP_DISCONNECTED: begin
                    att_start_next = start_eff;
                    att_vld_next   = 1'b1;
                    if (!throttled) begin
                        last_att_next = now;
                        last_vld_next = 1'b1;
                        if (!item.connect_ok) begin
                            restart = fail_expired;
                        end else begin
                            att_vld_next   = 1'b0;
                            last_vld_next  = 1'b0;
                            res.send_hello = 1'b1;
                            ka_sent_next   = now;
                            reply_next     = TIME_NONE;
                            warned_next    = SECS_NONE;
                        end
                    end
                end
                OP_RX_PAIR: begin
                    if (item.msg_first == BYTE_ALL_ONES && item.msg_second == BYTE_ALL_ONES) begin
                        reply_next = now;
                    end else if (item.msg_first != cfg.listen_input) begin
                        res.message_ignored = 1'b1;
                    end else begin
                        unique case (tally_code_t'(item.msg_second))
                            TALLY_OFF:     begin prev_next = 1'b0; prog_next = 1'b0; end
                            TALLY_PREVIEW: begin
                                prev_next = cfg.show_preview;
                                prog_next = 1'b0;
                            end
                            TALLY_PROGRAM: begin prev_next = 1'b0; prog_next = 1'b1; end
                            TALLY_BOTH:    begin prev_next = 1'b1; prog_next = 1'b1; end
                            default: ;     // unknown code keeps the lamps
                        endcase
                    end
                end
                OP_CONNECTED: begin
                    if (reply_late) begin
                        if (reply_expired) begin
                            restart = 1'b1;
                        end else if (secs != warned_reg) begin
                            res.warning_valid   = 1'b1;
                            res.warning_seconds = secs;
                            warned_next         = secs;
                        end
                    end else begin
                        warned_next = SECS_NONE;
                    end
                    if (!(reply_late && reply_expired) && ka_due) begin
                        res.send_keepalive = 1'b1;
                        ka_sent_next       = now;
                    end
                end
                OP_RESERVED: ;
            endcase
        end

        if (restart) begin
            att_start_next = '0;
            att_vld_next   = 1'b0;
            last_att_next  = '0;
            last_vld_next  = 1'b0;
            ka_sent_next   = '0;
            reply_next     = TIME_NONE;
            warned_next    = SECS_NONE;
            prev_next      = 1'b0;
            prog_next      = 1'b0;
            res.restart_request = 1'b1;
        end

        if (cfg.clear_link) begin
            att_vld_next  = 1'b0;
            last_vld_next = 1'b0;
        end

        res.preview_lamp = prev_next;
        res.program_lamp = prog_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            att_start_reg <= '0;
            att_vld_reg   <= 1'b0;
            last_att_reg  <= '0;
            last_vld_reg  <= 1'b0;
            ka_sent_reg   <= '0;
            reply_reg     <= TIME_NONE;
            warned_reg    <= SECS_NONE;
            prev_reg      <= 1'b0;
            prog_reg      <= 1'b0;
        end else begin
            att_start_reg <= att_start_next;
            att_vld_reg   <= att_vld_next;
            last_att_reg  <= last_att_next;
            last_vld_reg  <= last_vld_next;
            ka_sent_reg   <= ka_sent_next;
            reply_reg     <= reply_next;
            warned_reg    <= warned_next;
            prev_reg      <= prev_next;
            prog_reg      <= prog_next;
        end
    end

endmodule

@@ hw/rtl/tally_link_keepalive_supervisor.sv @@
// ----------------------------------------------------------------------------
// tally_link_keepalive_supervisor
// Tally link supervisor: connect throttling, keep-alive, tally lamps.
// ----------------------------------------------------------------------------
// Each input transaction is one event (disconnected poll, received byte pair
// or connected poll) with its millisecond time stamp, and yields exactly one
// result transaction. The block sustains one transaction per clock while
// m_tready is high: an input register feeds the combinational state update,
// and a result register holds the outcome, so m_tvalid rises once the
// transaction has moved from the input register into the result register.
// While a result waits on m_tready, one more transaction is taken into the
// input register and s_tready then stays low until the result leaves. The
// countdown divide by 1000 is one constant multiplication inside that update.
// The user must write registers over APB only while the block is idle (not enforced).
module tally_link_keepalive_supervisor
    import tlks_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // now_ms[31:0], connect_ok[32], msg_first[40:33],
                                   // msg_second[48:41], zero[55:49]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // send_hello[0], send_keepalive[1],
                                   // restart_request[2], message_ignored[3],
                                   // preview_lamp[4], program_lamp[5],
                                   // warning_valid[6], warning_seconds[22:7], zero[23]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_vld_reg;
    result_t out_res_reg;
    logic    out_vld_reg;
    result_t step_res;
    logic    advance;
    logic    s_fire;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_fire) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.operation  <= s_tuser;
            in_item_reg.now_ms     <= s_tdata[31:0];
            in_item_reg.connect_ok <= s_tdata[32];
            in_item_reg.msg_first  <= s_tdata[40:33];
            in_item_reg.msg_second <= s_tdata[48:41];
        end
    end

    tlks_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tlks_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step_en (advance),
        .item    (in_item_reg),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_res_reg};

endmodule

@@ hw/rtl/tlks_checker.sv @@
// ----------------------------------------------------------------------------
// tlks_checker
// Port-level checks on the supervisor's result stream, bound to the top.
// ----------------------------------------------------------------------------
`include "tally_link_keepalive_supervisor_macros.svh"

module tlks_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // a restart clears everything: lamps dark, no other flag, no countdown
    `TLKS_ASSERT_NOW(a_restart_alone, m_tvalid && m_tdata[2], (m_tdata[1:0] == 2'b00) && (m_tdata[22:3] == 20'd0))

    // countdown value only travels with its valid flag
    `TLKS_ASSERT_NOW(a_warn_zero, m_tvalid && !m_tdata[6], m_tdata[22:7] == 16'd0)

    // hello comes from a disconnected poll, never with connected-poll or pair flags
    `TLKS_ASSERT_NOW(a_hello_excl, m_tvalid && m_tdata[0], !m_tdata[1] && !m_tdata[3] && !m_tdata[6])

    // stalled result holds
    `TLKS_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // no result straight out of reset
    `TLKS_ASSERT_RST(a_rst_idle, !m_tvalid)

endmodule

bind tally_link_keepalive_supervisor tlks_checker u_tlks_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ bench/tally_link_keepalive_supervisor_checker.sv @@
// ----------------------------------------------------------------------------
// tally_link_keepalive_supervisor_checker
// Passive checker for the tally link supervisor. It tracks the APB
// register writes and every accepted input transaction. It predicts the
// result of each one with its own model of the link state, and compares
// each accepted result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module tally_link_keepalive_supervisor_checker
    import tlks_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // now_ms[31:0], connect_ok[32], msg_first[40:33],
                                   // msg_second[48:41], zero[55:49]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // send_hello[0], send_keepalive[1],
                                   // restart_request[2], message_ignored[3],
                                   // preview_lamp[4], program_lamp[5],
                                   // warning_valid[6], warning_seconds[22:7], zero[23]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MS_PER_SEC   = 1000;
    localparam int unsigned REPORT_LIMIT = 10;

    // register copies
    logic [7:0]  listen_q;
    logic [11:0] ka_sec;
    logic [11:0] rt_sec;
    logic        show_prev;

    // link state
    logic [31:0] run_start_ms;
    logic        run_active;
    logic [31:0] last_try_ms;
    logic        throttle_armed;
    logic [31:0] ka_sent_ms;
    logic [31:0] reply_ms;
    logic [15:0] warned_secs;
    logic        prv_lvl;
    logic        pgm_lvl;

    result_t pending_results[$];
    result_t got_res;
    result_t want_res;
    result_t next_res;
    item_t   in_item;
    int      err_total;

    task automatic clear_link_state();
        run_start_ms   = '0;
        run_active     = 1'b0;
        last_try_ms    = '0;
        throttle_armed = 1'b0;
        ka_sent_ms     = '0;
        reply_ms       = TIME_NONE;
        warned_secs    = SECS_NONE;
        prv_lvl        = 1'b0;
        pgm_lvl        = 1'b0;
    endtask

    task automatic advance_link(input item_t it, output result_t r);
        logic [31:0] restart_ms;
        logic [31:0] ka_ms;
        logic [31:0] span;
        logic [31:0] gap_ms;
        logic [31:0] secs;
        logic        overdue;
        r          = '0;
        restart_ms = {20'd0, rt_sec} * 32'd1000;
        ka_ms      = {20'd0, ka_sec} * 32'd1000;
        overdue    = 1'b0;
        case (it.operation)
            OP_DISCONNECTED: begin
                if (!run_active) begin
                    run_start_ms = it.now_ms;
                    run_active   = 1'b1;
                end
                span = it.now_ms - last_try_ms;
                if (!(throttle_armed && span < RETRY_INTERVAL_MS)) begin
                    last_try_ms    = it.now_ms;
                    throttle_armed = 1'b1;
                    if (!it.connect_ok) begin
                        span = it.now_ms - run_start_ms;
                        if (span >= restart_ms) begin
                            r.restart_request = 1'b1;
                            clear_link_state();
                        end
                    end else begin
                        run_active     = 1'b0;
                        throttle_armed = 1'b0;
                        r.send_hello   = 1'b1;
                        ka_sent_ms     = it.now_ms;
                        reply_ms       = TIME_NONE;
                        warned_secs    = SECS_NONE;
                    end
                end
            end
            OP_RX_PAIR: begin
                if (it.msg_first == BYTE_ALL_ONES && it.msg_second == BYTE_ALL_ONES) begin
                    reply_ms = it.now_ms;
                end else if (it.msg_first != listen_q) begin
                    r.message_ignored = 1'b1;
                end else begin
                    case (it.msg_second)
                        TALLY_OFF: begin
                            prv_lvl = 1'b0;
                            pgm_lvl = 1'b0;
                        end
                        TALLY_PREVIEW: begin
                            prv_lvl = show_prev;
                            pgm_lvl = 1'b0;
                        end
                        TALLY_PROGRAM: begin
                            prv_lvl = 1'b0;
                            pgm_lvl = 1'b1;
                        end
                        TALLY_BOTH: begin
                            prv_lvl = 1'b1;
                            pgm_lvl = 1'b1;
                        end
                        default: ;  // unknown code: lamps hold
                    endcase
                end
            end
            OP_CONNECTED: begin
                gap_ms = ka_sent_ms - reply_ms;
                // reply watch is armed only once a keep-alive went out a full
                // interval after the last reply
                if (reply_ms < ka_sent_ms && gap_ms >= ka_ms) begin
                    span = it.now_ms - reply_ms;
                    if (span >= restart_ms) begin
                        r.restart_request = 1'b1;
                        clear_link_state();
                        overdue = 1'b1;
                    end else begin
                        secs = (restart_ms - span + MS_PER_SEC - 1) / MS_PER_SEC;
                        if (secs[15:0] != warned_secs) begin
                            r.warning_valid   = 1'b1;
                            r.warning_seconds = secs[15:0];
                            warned_secs       = secs[15:0];
                        end
                    end
                end else begin
                    warned_secs = SECS_NONE;
                end
                span = it.now_ms - ka_sent_ms;
                if (!overdue && span >= ka_ms) begin
                    r.send_keepalive = 1'b1;
                    ka_sent_ms       = it.now_ms;
                end
            end
            default: ;
        endcase
        r.preview_lamp = prv_lvl;
        r.program_lamp = pgm_lvl;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            listen_q  = 8'd0;
            ka_sec    = 12'd5;
            rt_sec    = 12'd30;
            show_prev = 1'b1;
            clear_link_state();
            pending_results.delete();
            err_total = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_LISTEN_INPUT:  listen_q = pwdata[7:0];
                    REG_KEEPALIVE_SEC: ka_sec   = pwdata[11:0];
                    REG_RESTART_SEC:   rt_sec   = pwdata[11:0];
                    REG_SHOW_PREVIEW:  show_prev = pwdata[0];
                    default: ;
                endcase
                // any write but show_preview drops the attempt run and throttle
                if (reg_idx_t'(paddr[3:2]) != REG_SHOW_PREVIEW) begin
                    run_active     = 1'b0;
                    throttle_armed = 1'b0;
                end
            end
            if (m_tvalid && m_tready) begin
                got_res = m_tdata[22:0];
                if (pending_results.size() == 0) begin
                    if (err_total < REPORT_LIMIT)
                        $display("%0t: result transaction with nothing expected: %h",
                                 $realtime, m_tdata);
                    err_total++;
                end else begin
                    want_res = pending_results.pop_front();
                    if (got_res !== want_res) begin
                        if (err_total < REPORT_LIMIT)
                            $display({"%0t: result mismatch\n",
                                      "  exp hello=%0d ka=%0d rst=%0d ign=%0d prv=%0d ",
                                      "pgm=%0d wv=%0d ws=%0d\n",
                                      "  got hello=%0d ka=%0d rst=%0d ign=%0d prv=%0d ",
                                      "pgm=%0d wv=%0d ws=%0d"},
                                     $realtime,
                                     want_res.send_hello, want_res.send_keepalive,
                                     want_res.restart_request, want_res.message_ignored,
                                     want_res.preview_lamp, want_res.program_lamp,
                                     want_res.warning_valid, want_res.warning_seconds,
                                     got_res.send_hello, got_res.send_keepalive,
                                     got_res.restart_request, got_res.message_ignored,
                                     got_res.preview_lamp, got_res.program_lamp,
                                     got_res.warning_valid, got_res.warning_seconds);
                        err_total++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                in_item = {s_tdata[48:0], s_tuser};
                advance_link(in_item, next_res);
                pending_results.push_back(next_res);
            end
        end
        mismatches  <= err_total;
        outstanding <= pending_results.size();
    end

endmodule

@@ bench/tally_link_keepalive_supervisor_tb.sv @@
// ----------------------------------------------------------------------------
// tally_link_keepalive_supervisor_tb
// Stimulus and verdict for the tally link supervisor. A directed opening
// covers lamps, throttling, restarts, countdown warnings and zero settings.
// Random phases then run link sessions under varied register settings,
// with random gaps on the input side and random stalls on the result side.
// A separate checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tally_link_keepalive_supervisor_tb
    import tlks_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 119;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;   // now_ms[31:0], connect_ok[32], msg_first[40:33],
                                  // msg_second[48:41], zero[55:49]
    logic [1:0]  s_tuser  = '0;   // operation[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // send_hello[0], send_keepalive[1],
                                  // restart_request[2], message_ignored[3],
                                  // preview_lamp[4], program_lamp[5],
                                  // warning_valid[6], warning_seconds[22:7], zero[23]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int          err_count;
    int          pending_count;

    logic [31:0] clock_ms;
    logic [7:0]  listen_cur;
    bit          tx_burst;
    bit          rx_burst;
    bit          link_up;
    bit          replies_on;

    tally_link_keepalive_supervisor u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tally_link_keepalive_supervisor_checker u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (err_count),
        .outstanding (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side: outside burst mode, stall for a random while before each transaction
    initial begin : result_sink
        int stall;
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [31:0] now,
                             input logic ok, input logic [7:0] first,
                             input logic [7:0] second);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, second, first, ok, now};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    // upper bits beyond each register width carry junk on purpose
    task automatic program_regs(input logic [3:0] mask, input logic [7:0] li,
                                input logic [11:0] ka, input logic [11:0] rt,
                                input logic sp);
        logic [31:0] junk;
        junk = $urandom;
        if (mask[REG_LISTEN_INPUT]) begin
            write_reg(REG_LISTEN_INPUT, {junk[31:8], li});
            listen_cur = li;
        end
        if (mask[REG_KEEPALIVE_SEC]) write_reg(REG_KEEPALIVE_SEC, {junk[31:12], ka});
        if (mask[REG_RESTART_SEC])   write_reg(REG_RESTART_SEC, {junk[31:12], rt});
        if (mask[REG_SHOW_PREVIEW])  write_reg(REG_SHOW_PREVIEW, {junk[31:1], sp});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // one random transaction shaped like a link session: mostly disconnected polls
    // while down, mostly connected polls, keep-alive replies and tally pairs while up
    task automatic random_item();
        int          pick;
        int          step_sel;
        logic [31:0] step;
        logic [31:0] noise;
        logic        ok;
        step_sel = $urandom_range(0, 99);
        if (step_sel < 5)       step = 0;
        else if (step_sel < 80) step = $urandom_range(1, 1500);
        else if (step_sel < 95) step = $urandom_range(1500, 6000);
        else if (step_sel < 99) step = $urandom_range(6000, 40000);
        else                    step = $urandom;
        clock_ms = clock_ms + step;
        if ($urandom_range(0, 99) < 4) link_up = !link_up;
        if ($urandom_range(0, 99) < 5) replies_on = !replies_on;
        noise = $urandom;
        pick  = $urandom_range(0, 99);
        if (pick < 3) begin
            send_item(OP_RESERVED, clock_ms, noise[0], noise[15:8], noise[23:16]);
        end else if (!link_up) begin
            if (pick < 75) begin
                ok = ($urandom_range(0, 3) == 0);
                send_item(OP_DISCONNECTED, clock_ms, ok, noise[15:8], noise[23:16]);
                if (ok) link_up = 1'b1;
            end else if (pick < 88) begin
                send_item(OP_CONNECTED, clock_ms, noise[0], noise[15:8], noise[23:16]);
            end else begin
                send_item(OP_RX_PAIR, clock_ms, noise[0], noise[15:8], noise[23:16]);
            end
        end else begin
            if (pick < 45) begin
                send_item(OP_CONNECTED, clock_ms, noise[0], noise[15:8], noise[23:16]);
            end else if (pick < 65) begin
                if (replies_on)
                    send_item(OP_RX_PAIR, clock_ms, noise[0], BYTE_ALL_ONES, BYTE_ALL_ONES);
                else
                    send_item(OP_CONNECTED, clock_ms, noise[0], noise[15:8], noise[23:16]);
            end else if (pick < 82) begin
                send_item(OP_RX_PAIR, clock_ms, noise[0], listen_cur,
                          ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3))
                                                     : noise[23:16]);
            end else if (pick < 92) begin
                send_item(OP_RX_PAIR, clock_ms, noise[0], noise[15:8], noise[23:16]);
            end else begin
                send_item(OP_DISCONNECTED, clock_ms, noise[0], noise[15:8], noise[23:16]);
            end
        end
    endtask

    initial begin : stimulus
        logic [7:0]  li;
        logic [11:0] ka;
        logic [11:0] rt;
        tx_burst   = 1'b0;
        rx_burst   = 1'b0;
        listen_cur = 8'd0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: listen 0, keep-alive 5 s, restart 30 s, preview shown
        send_item(OP_RESERVED, $urandom, 1'b1, 8'hFF, 8'hFF);   // unused operation
        send_item(OP_RX_PAIR, 32'd100, 1'b0, 8'd0, TALLY_PREVIEW);
        send_item(OP_RX_PAIR, 32'd100, 1'b0, 8'd0, TALLY_PROGRAM);
        send_item(OP_RX_PAIR, 32'd100, 1'b0, 8'd0, TALLY_BOTH);
        send_item(OP_RX_PAIR, 32'd100, 1'b0, 8'd0, 8'd200);     // unknown code
        send_item(OP_RX_PAIR, 32'd100, 1'b0, 8'd0, TALLY_OFF);
        send_item(OP_RX_PAIR, 32'd100, 1'b0, 8'd7, TALLY_PREVIEW); // other input
        send_item(OP_DISCONNECTED, 32'd0, 1'b0, 8'd0, 8'd0);
        send_item(OP_DISCONNECTED, 32'd500, 1'b1, 8'd0, 8'd0);  // throttled
        send_item(OP_DISCONNECTED, 32'd1000, 1'b0, 8'd0, 8'd0);
        send_item(OP_DISCONNECTED, 32'd31000, 1'b0, 8'd0, 8'd0); // restart
        send_item(OP_DISCONNECTED, 32'd32000, 1'b1, 8'd0, 8'd0); // hello
        send_item(OP_RX_PAIR, 32'd33000, 1'b0, BYTE_ALL_ONES, BYTE_ALL_ONES);
        send_item(OP_CONNECTED, 32'd37000, 1'b0, 8'd0, 8'd0);
        send_item(OP_CONNECTED, 32'd42000, 1'b0, 8'd0, 8'd0);
        send_item(OP_CONNECTED, 32'd43500, 1'b0, 8'd0, 8'd0);   // countdown starts
        send_item(OP_CONNECTED, 32'd62999, 1'b0, 8'd0, 8'd0);   // last second
        send_item(OP_CONNECTED, 32'd63000, 1'b0, 8'd0, 8'd0);   // reply timeout
        send_item(OP_DISCONNECTED, 32'hFFFF_FFFF, 1'b1, 8'hFF, 8'hFF);
        drain();

        // preview hidden; this write keeps the attempt run
        program_regs(4'b1000, 8'd0, 12'd0, 12'd0, 1'b0);
        send_item(OP_RX_PAIR, 32'd500, 1'b0, 8'd0, TALLY_PREVIEW);
        drain();

        // listen to 0xFF with zero keep-alive and restart settings
        program_regs(4'b1111, 8'hFF, 12'd0, 12'd0, 1'b1);
        send_item(OP_RX_PAIR, 32'd10, 1'b0, BYTE_ALL_ONES, BYTE_ALL_ONES);
        send_item(OP_RX_PAIR, 32'd20, 1'b0, BYTE_ALL_ONES, TALLY_PREVIEW);
        send_item(OP_DISCONNECTED, 32'd30, 1'b0, 8'd0, 8'd0);   // instant restart
        send_item(OP_DISCONNECTED, 32'd40, 1'b1, 8'd0, 8'd0);
        send_item(OP_CONNECTED, 32'd50, 1'b0, 8'd0, 8'd0);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            li = $urandom;
            ka = $urandom_range(1, 5);
            rt = $urandom_range(1, 12);
            case (ph)
                0: program_regs(4'b1111, li, 12'd1, 12'd2, 1'b1);
                1: program_regs(4'b1111, 8'd0, 12'd4095, 12'd4095, 1'b0);
                2: program_regs(4'b1111, 8'hFF, 12'd0, rt, 1'b1);
                3: program_regs(4'b1000, li, ka, rt, 1'($urandom));
                4: program_regs(4'b1111, li, ka, 12'd0, 1'($urandom));
                default: begin
                    if ($urandom_range(0, 1) == 0) li = 8'($urandom_range(0, 2));
                    program_regs(4'b1111, li, ka, rt, 1'($urandom));
                end
            endcase
            tx_burst   = ($urandom_range(0, 3) == 0);
            rx_burst   = ($urandom_range(0, 3) == 0);
            link_up    = 1'b0;
            replies_on = 1'b1;
            clock_ms   = (ph % 3 == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 20000)
                                       : $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_item();
                // hold off until the block has drained, then resume
                if (ph % 2 == 0 && n == PHASE_ITEMS / 2) drain();
            end
            drain();
        end

        if (err_count == 0 && pending_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/tlks_pkg.sv
hw/rtl/tlks_regs.sv
hw/rtl/tlks_core.sv
hw/rtl/tally_link_keepalive_supervisor.sv
hw/rtl/tlks_checker.sv
bench/tally_link_keepalive_supervisor_checker.sv
bench/tally_link_keepalive_supervisor_tb.sv
